>>> hdl/cpcc_pkg.sv
// cpcc_pkg: payload types, status codes and crc constants of the command packet crc checker
// no dependencies; used by cpcc_crc_byte, command_packet_crc_checker and tb
package cpcc_pkg;

  localparam int unsigned CrcWidth = 32;
  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcTop  = 32'h8000_0000;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;

  // shortest length byte that leaves room for the four crc bytes
  localparam logic [7:0] MinLength = 8'd4;
  // length byte that the frame format cannot use
  localparam logic [7:0] BadLength = 8'd255;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusMismatch = 2'd1,
    StatusMalform  = 2'd2
  } status_e;

  typedef struct packed {
    logic       start_of_packet;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e              check_status;
    logic [7:0]           command_code;
    logic [CrcWidth-1:0]  computed_crc;
  } out_t;

  // row j holds the input bits that feed output bit j after 32 msb-first shifts
  typedef logic [CrcWidth-1:0][CrcWidth-1:0] crc_mat_t;

  // evaluated at elaboration only
  function automatic crc_mat_t crc_shift_matrix();
    crc_mat_t m;
    logic [CrcWidth-1:0] r;
    m = '0;
    for (int i = 0; i < CrcWidth; i++) begin
      r = CrcWidth'(1) << i;
      for (int k = 0; k < CrcWidth; k++) begin
        if ((r & CrcTop) != '0) begin
          r = (r << 1) ^ CrcPoly;
        end else begin
          r = r << 1;
        end
      end
      for (int j = 0; j < CrcWidth; j++) begin
        m[j][i] = r[j];
      end
    end
    return m;
  endfunction

  localparam crc_mat_t CrcShiftMat = crc_shift_matrix();

endpackage

>>> hdl/cpcc_crc_byte.sv
// cpcc_crc_byte: folds one byte into the crc, 32 shift steps flattened to an xor network
// depends on cpcc_pkg
module cpcc_crc_byte (
  input  logic [cpcc_pkg::CrcWidth-1:0] crc_i,
  input  logic [7:0]                    byte_i,
  output logic [cpcc_pkg::CrcWidth-1:0] crc_o
);
  import cpcc_pkg::*;

  logic [CrcWidth-1:0] mixed;

  assign mixed = crc_i ^ {{(CrcWidth-8){1'b0}}, byte_i};

  // each output bit is the parity of a fixed subset of the mixed word
  always_comb begin
    for (int j = 0; j < CrcWidth; j++) begin
      crc_o[j] = ^(mixed & CrcShiftMat[j]);
    end
  end

endmodule

>>> hdl/command_packet_crc_checker.sv
// command_packet_crc_checker: top level, checks framed command packets byte by byte
// depends on cpcc_pkg and cpcc_crc_byte
//
//  channel  | valid/ready            | payload                   | transaction
//  ---------+------------------------+---------------------------+---------------------------
//  in       | in_valid_i/in_ready_o  | in_data_i  (cpcc_pkg::in_t)  | one packet byte
//  out      | out_valid_o/out_ready_i| out_data_o (cpcc_pkg::out_t) | one packet status
//
// one byte per cycle sustained while no status waits on a stalled out_ready_i; a byte is
// taken into the input register, then the crc xor network and compare load the result
// register, which drives out_valid_o; a malformed length or a packet's last crc byte gives a status
// reset puts the block idle, waiting for a length byte; no clearing pass is needed
// a stalled result holds in the output register; one more byte is still taken into
// the input register, after which in_ready_o follows out_ready_i
module command_packet_crc_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpcc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cpcc_pkg::out_t  out_data_o
);
  import cpcc_pkg::*;

  // input register stage
  logic in_valid_q;
  in_t  in_q;
  logic advance;

  // packet state
  logic                in_pkt_q, in_pkt_d;
  logic                expect_cmd_q, expect_cmd_d;  // next byte is the command byte
  logic [7:0]          rem_q, rem_d;                // bytes still expected
  logic [CrcWidth-1:0] crc_q, crc_d;
  logic [3:0][7:0]     host_q, host_d;              // host crc, lane per byte
  logic [7:0]          cmd_q, cmd_d;

  // result register
  logic out_valid_q;
  out_t out_q;
  logic res_load;
  out_t res;

  logic [CrcWidth-1:0] crc_base, crc_next;
  logic [2:0]          lane_wide;
  logic [1:0]          lane;
  logic [7:0]          rem_dec;

  // input stage moves on whenever the result register can take a new status
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // a length byte restarts from the initial value, a body byte extends the running crc
  assign crc_base = in_q.start_of_packet ? CrcInit : crc_q;

  cpcc_crc_byte u_crc_byte (
    .crc_i  (crc_base),
    .byte_i (in_q.data_byte),
    .crc_o  (crc_next)
  );

  // crc byte lane: four bytes left is lane 0, one byte left is lane 3
  assign lane_wide = 3'd4 - rem_q[2:0];
  assign lane      = lane_wide[1:0];
  assign rem_dec   = rem_q - 8'd1;

  always_comb begin
    in_pkt_d     = in_pkt_q;
    expect_cmd_d = expect_cmd_q;
    rem_d        = rem_q;
    crc_d        = crc_q;
    host_d       = host_q;
    cmd_d        = cmd_q;
    res_load     = 1'b0;
    res          = '{check_status: StatusOk, command_code: '0, computed_crc: '0};

    if (in_valid_q && advance) begin
      if (in_q.start_of_packet) begin
        if (in_q.data_byte < MinLength || in_q.data_byte == BadLength) begin
          // malformed length: report at once and go idle
          in_pkt_d     = 1'b0;
          expect_cmd_d = 1'b0;
          rem_d        = '0;
          crc_d        = CrcInit;
          res_load     = 1'b1;
          res          = '{check_status: StatusMalform, command_code: '0, computed_crc: '0};
        end else begin
          // new packet, abandons any packet still open
          in_pkt_d     = 1'b1;
          expect_cmd_d = 1'b1;
          rem_d        = in_q.data_byte;
          crc_d        = crc_next;
          host_d       = '0;
          cmd_d        = '0;
        end
      end else if (in_pkt_q) begin
        if (expect_cmd_q) begin
          cmd_d = in_q.data_byte;
        end
        expect_cmd_d = 1'b0;
        if (rem_q > 8'd4) begin
          crc_d = crc_next;
        end else begin
          host_d[lane] = in_q.data_byte;
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          // last crc byte: compare against the crc of the covered bytes
          in_pkt_d = 1'b0;
          res_load = 1'b1;
          res.check_status = (crc_q == host_d) ? StatusOk : StatusMismatch;
          res.command_code = cmd_d;
          res.computed_crc = crc_q;
        end
      end
      // a body byte while idle is dropped
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q     <= 1'b0;
      expect_cmd_q <= 1'b0;
      rem_q        <= '0;
      crc_q        <= CrcInit;
      host_q       <= '0;
      cmd_q        <= '0;
    end else begin
      in_pkt_q     <= in_pkt_d;
      expect_cmd_q <= expect_cmd_d;
      rem_q        <= rem_d;
      crc_q        <= crc_d;
      host_q       <= host_d;
      cmd_q        <= cmd_d;
    end
  end

  // result register: loads a status, or empties when the status is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // an open packet always has bytes left to come
  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pkt_q |-> rem_q != '0)
    else $error("open packet with no bytes remaining");

  // the command byte is only awaited right after a valid length byte
  a_cmd_after_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expect_cmd_q |-> in_pkt_q && rem_q >= MinLength)
    else $error("command byte expected outside a fresh packet");

  // a malformed report carries no command and no crc
  a_malform_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.check_status == StatusMalform
      |-> out_q.command_code == '0 && out_q.computed_crc == '0)
    else $error("malformed status with nonzero payload");

  // a status waiting for the sink is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending status lost or changed");
`endif

endmodule

>>> bench/tb.sv
// tb: self-checking testbench for command_packet_crc_checker
// depends on cpcc_pkg (payload types, status codes, crc constants) and the rtl under hdl
// a byte-level status predictor is checked against every result transaction
`timescale 1ns / 1ps

module tb;
  import cpcc_pkg::*;

  // watchdog: cycles in a row with no transaction on either channel
  localparam int unsigned QuietLimit = 4000;
  // longest sender gap before one byte
  localparam int unsigned MaxGap = 30;
  // cycles waited after the last owed status, so a stray extra status is still seen
  localparam int unsigned TailCycles = 6;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  command_packet_crc_checker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // idle percentages for each side, changed between phases
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  int unsigned bytes_sent;
  int unsigned fault_count;
  int unsigned quiet_cycles;

  // statuses still owed by the block, oldest first
  out_t pending_status_q[$];

  // predictor state, mirrors the block's packet tracking
  logic [31:0] pred_crc;
  logic [7:0]  pred_left;
  logic [7:0]  pred_pos;
  logic [31:0] pred_host_crc;
  logic [7:0]  pred_cmd;
  logic        pred_busy;

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one byte folded into the accumulator, msb-first shifts
  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'd0, b};
    for (int k = 0; k < 32; k++) begin
      if (r[31]) begin
        r = (r << 1) ^ CrcPoly;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // advance the predictor by one accepted byte, queue any status it owes
  task automatic predict_status(input in_t t);
    out_t r;
    logic [1:0] slot;
    if (t.start_of_packet) begin
      if (t.data_byte < MinLength || t.data_byte == BadLength) begin
        // malformed length: status at once, back to idle
        pred_busy = 1'b0;
        pred_left = '0;
        pred_pos  = '0;
        pred_crc  = CrcInit;
        r.check_status = StatusMalform;
        r.command_code = '0;
        r.computed_crc = '0;
        pending_status_q.push_back(r);
      end else begin
        // a start also abandons any packet in flight
        pred_crc      = crc_fold(CrcInit, t.data_byte);
        pred_host_crc = '0;
        pred_cmd      = '0;
        pred_left     = t.data_byte;
        pred_pos      = 8'd1;
        pred_busy     = 1'b1;
      end
    end else if (pred_busy) begin
      if (pred_pos == 8'd1) begin
        pred_cmd = t.data_byte;
      end
      if (pred_left > 8'd4) begin
        pred_crc = crc_fold(pred_crc, t.data_byte);
      end else begin
        // host crc arrives low byte first
        slot = 2'(8'd4 - pred_left);
        pred_host_crc = pred_host_crc | (32'(t.data_byte) << (8 * slot));
      end
      pred_pos  = pred_pos + 8'd1;
      pred_left = pred_left - 8'd1;
      if (pred_left == 8'd0) begin
        pred_busy = 1'b0;
        r.check_status = (pred_crc == pred_host_crc) ? StatusOk : StatusMismatch;
        r.command_code = pred_cmd;
        r.computed_crc = pred_crc;
        pending_status_q.push_back(r);
      end
    end
    // bytes while idle are dropped, nothing owed
  endtask

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  // send one byte; entered and left at a falling edge
  task automatic send_byte(input logic sop, input logic [7:0] b);
    int unsigned gap;
    in_t t;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) begin
      gap++;
    end
    t.start_of_packet = sop;
    t.data_byte       = b;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    // wait for the transaction to be taken
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predict_status(t);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // build a framed packet of length byte len and send its first keep bytes
  task automatic send_packet(input int unsigned len, input logic [7:0] cmd,
                             input bit good_crc, input int unsigned keep);
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [31:0] acc;
    acc = crc_fold(CrcInit, 8'(len));
    frame.push_back(8'(len));
    // covered body: command byte then filler, none when len is four
    for (int unsigned i = 1; i + 4 <= len; i++) begin
      b = (i == 1) ? cmd : 8'($urandom_range(255));
      acc = crc_fold(acc, b);
      frame.push_back(b);
    end
    if (!good_crc) begin
      acc = acc ^ (32'd1 << $urandom_range(31));
    end
    for (int i = 0; i < 4; i++) begin
      frame.push_back(acc[8*i +: 8]);
    end
    for (int unsigned i = 0; i < keep && i < frame.size(); i++) begin
      send_byte(i == 0, frame[i]);
    end
  endtask

  // ---------------------------------------------------------------- directed tests

  // bytes without a start while idle must be dropped
  task automatic test_idle_bytes();
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
  endtask

  // lengths too short for the crc, and the unusable all-ones length
  task automatic test_malformed_lengths();
    send_byte(1'b1, 8'd0);
    send_byte(1'b1, 8'd1);
    send_byte(1'b1, 8'd2);
    send_byte(1'b1, 8'd3);
    send_byte(1'b1, BadLength);
  endtask

  // length four: only the length byte is covered, command is the first crc byte
  task automatic test_shortest_packet();
    send_packet(4, 8'h00, 1'b1, 5);
  endtask

  // host crc off by one bit must give a mismatch
  task automatic test_crc_mismatch();
    send_packet(5, 8'hFF, 1'b0, 6);
  endtask

  // a start inside a packet drops the old packet silently
  task automatic test_restart_in_packet();
    send_packet(8, 8'h31, 1'b1, 3);
    send_packet(4, 8'h00, 1'b1, 5);
  endtask

  // ---------------------------------------------------------------- random traffic

  // mostly whole packets with random content, the rest noise and broken frames
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned malformed[5];
    malformed = '{0, 1, 2, 3, 255};
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      // short packets dominate, a few run to the longest length
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 254) : $urandom_range(4, 24);
      if (pick < 70) begin
        send_packet(len, 8'($urandom_range(255)), $urandom_range(99) < 60, len + 1);
      end else if (pick < 80) begin
        send_packet(len, 8'($urandom_range(255)), 1'b1, $urandom_range(1, len));
      end else if (pick < 88) begin
        send_byte(1'b1, 8'(malformed[$urandom_range(4)]));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range(255)));
      end else begin
        send_byte(1'b1, 8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  // receiver side: random stalls at the configured rate
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // each result transaction against the oldest owed status
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        note_fault($sformatf("unexpected status: status %0d cmd %02h crc %08h",
                             out_data_o.check_status, out_data_o.command_code,
                             out_data_o.computed_crc));
      end else begin
        want = pending_status_q.pop_front();
        if (out_data_o.check_status !== want.check_status) begin
          note_fault($sformatf("check_status: expected %0d, got %0d",
                               want.check_status, out_data_o.check_status));
        end
        if (out_data_o.command_code !== want.command_code) begin
          note_fault($sformatf("command_code: expected %02h, got %02h",
                               want.command_code, out_data_o.command_code));
        end
        if (out_data_o.computed_crc !== want.computed_crc) begin
          note_fault($sformatf("computed_crc: expected %08h, got %08h",
                               want.computed_crc, out_data_o.computed_crc));
        end
      end
    end
  end

  // quiet cycle counter for the watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: a hang ends the run as a failure
  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    tx_idle_pct   = 27;
    rx_idle_pct   = 71;
    bytes_sent    = 0;
    fault_count   = 0;
    pred_crc      = CrcInit;
    pred_left     = '0;
    pred_pos      = '0;
    pred_host_crc = '0;
    pred_cmd      = '0;
    pred_busy     = 1'b0;

    // reset held, then released at a falling edge
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_bytes();
    test_malformed_lengths();
    test_shortest_packet();
    test_crc_mismatch();
    test_restart_in_packet();

    // sender idles lightly and receiver heavily, then swapped, then full rate
    test_random_traffic(27, 71, 410);
    test_random_traffic(71, 27, 410);
    test_random_traffic(0, 0, 410);

    in_valid_i <= 1'b0;
    // drain whatever the block still owes, the watchdog covers a hang
    while (pending_status_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cpcc_pkg.sv
hdl/cpcc_crc_byte.sv
hdl/command_packet_crc_checker.sv
bench/tb.sv
